FILE: rtl/rpa_pkg.sv
`default_nettype none
package rpa_pkg;
    localparam int N_CORDIC = 31;
    localparam logic signed [35:0] Q30_PI = 36'sd3373259426;
    localparam logic signed [35:0] Q30_TWO_PI = 36'sd6746518852;
    localparam logic signed [35:0] Q30_HALF_PI = 36'sd1686629713;
    localparam logic signed [33:0] CORDIC_K = 34'sd652032874;

    typedef logic signed [35:0] t_ang;
    typedef logic signed [33:0] t_trig;

    typedef struct packed {
        logic signed [31:0] px, py, pz;
        logic signed [31:0] ax, ay, az;
        logic signed [17:0] ux, uy, uz;
        logic signed [33:0] vx, vy, vz;
        logic signed [35:0] sdot;
        logic signed [36:0] wx, wy, wz;
        logic signed [36:0] xx, xy, xz;
        logic signed [38:0] yx, yy, yz;
        logic on_axis;
        logic flip;
    } t_geo;

    function automatic t_ang atan_val(input int i);
        logic [31:0] t [0:30];
        t = '{32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
              32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
              32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
              32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
              32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
              32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
              32'h00000001};
        return t_ang'({4'b0, t[i]});
    endfunction
endpackage
`default_nettype wire

FILE: rtl/rpa_cell.sv
`default_nettype none
module rpa_cell
    import rpa_pkg::*;
#(
    parameter int STEP = 0
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_vld,
    input  wire t_trig   i_x,
    input  wire t_trig   i_y,
    input  wire t_ang    i_z,
    input  wire t_geo    i_geo,
    output logic         o_vld,
    output t_trig        o_x,
    output t_trig        o_y,
    output t_ang         o_z,
    output t_geo         o_geo
);
    logic r_vld;
    t_trig r_x, r_y;
    t_ang r_z;
    t_geo r_geo;
    t_trig n_x, n_y;
    t_ang n_z;

    always_comb begin
        if (!i_z[35]) begin
            n_x = i_x - (i_y >>> STEP);
            n_y = i_y + (i_x >>> STEP);
            n_z = i_z - atan_val(STEP);
        end else begin
            n_x = i_x + (i_y >>> STEP);
            n_y = i_y - (i_x >>> STEP);
            n_z = i_z + atan_val(STEP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= 1'b0;
        else r_vld <= i_vld;
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
        r_geo <= i_geo;
    end

    assign o_vld = r_vld;
    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;
    assign o_geo = r_geo;
endmodule
`default_nettype wire

FILE: rtl/rotate_point_about_axis.sv
// Channel  | Ports                                   | Handshake
// input    | i_point_*, i_anchor_*, i_axis_*, i_angle | i_start and not o_busy
// result   | o_rotated_*, o_on_axis                  | o_done, one cycle
// One word is accepted every cycle; o_busy is always low.
// The pipeline has 6 geometry stages, 31 rotation cells and 5 output stages.
// The rotation cells hold the angle pipeline and make up most of the latency.
// Reset clears only the valid bits. The receiver cannot stall.
`default_nettype none
module rotate_point_about_axis
    import rpa_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_start,
    output logic               o_busy,
    input  wire signed [31:0]  i_point_x,
    input  wire signed [31:0]  i_point_y,
    input  wire signed [31:0]  i_point_z,
    input  wire signed [31:0]  i_anchor_x,
    input  wire signed [31:0]  i_anchor_y,
    input  wire signed [31:0]  i_anchor_z,
    input  wire signed [17:0]  i_axis_x,
    input  wire signed [17:0]  i_axis_y,
    input  wire signed [17:0]  i_axis_z,
    input  wire signed [31:0]  i_angle,
    output logic               o_done,
    output logic signed [31:0] o_rotated_x,
    output logic signed [31:0] o_rotated_y,
    output logic signed [31:0] o_rotated_z,
    output logic               o_on_axis
);
    assign o_busy = 1'b0;

    logic [5:0] r_v;
    t_geo r_g0, r_g1, r_g2, r_g3, r_g4, r_g5;
    t_ang r_z0, r_z1, r_z2, r_z3, r_z4, r_z5;
    logic signed [51:0] r_m0, r_m1, r_m2;
    logic signed [55:0] r_c0, r_c1, r_c2, r_c3, r_c4, r_c5;

    t_ang n_za, n_zb;
    logic n_flip;
    logic signed [53:0] n_dot;
    logic signed [53:0] n_wx, n_wy, n_wz;
    logic signed [36:0] n_xx, n_xy, n_xz;
    t_geo n_g0, n_g1, n_g2, n_g3, n_g4;

    always_comb begin
        n_za = t_ang'(r_z0);
        if (n_za > Q30_PI) n_za = n_za - Q30_TWO_PI;
        if (n_za < -Q30_PI) n_za = n_za + Q30_TWO_PI;
        n_zb = n_za;
        n_flip = 1'b0;
        if (n_za > Q30_HALF_PI) begin
            n_zb = n_za - Q30_PI;
            n_flip = 1'b1;
        end else if (n_za < -Q30_HALF_PI) begin
            n_zb = n_za + Q30_PI;
            n_flip = 1'b1;
        end
        n_dot = 54'(r_m0) + 54'(r_m1) + 54'(r_m2) + 54'sd32768;
        n_wx = 54'(r_g2.sdot * r_g2.ux) + 54'sd32768;
        n_wy = 54'(r_g2.sdot * r_g2.uy) + 54'sd32768;
        n_wz = 54'(r_g2.sdot * r_g2.uz) + 54'sd32768;
        n_xx = 37'(r_g3.vx) - r_g3.wx;
        n_xy = 37'(r_g3.vy) - r_g3.wy;
        n_xz = 37'(r_g3.vz) - r_g3.wz;

        n_g0 = '0;
        n_g0.px = i_point_x; n_g0.py = i_point_y; n_g0.pz = i_point_z;
        n_g0.ax = i_anchor_x; n_g0.ay = i_anchor_y; n_g0.az = i_anchor_z;
        n_g0.ux = i_axis_x; n_g0.uy = i_axis_y; n_g0.uz = i_axis_z;
        n_g0.vx = 34'(i_point_x) - 34'(i_anchor_x);
        n_g0.vy = 34'(i_point_y) - 34'(i_anchor_y);
        n_g0.vz = 34'(i_point_z) - 34'(i_anchor_z);
        n_g1 = r_g0;
        n_g1.flip = n_flip;
        n_g2 = r_g1;
        n_g2.sdot = 36'(n_dot >>> 16);
        n_g3 = r_g2;
        n_g3.wx = 37'(n_wx >>> 16);
        n_g3.wy = 37'(n_wy >>> 16);
        n_g3.wz = 37'(n_wz >>> 16);
        n_g4 = r_g3;
        n_g4.xx = n_xx; n_g4.xy = n_xy; n_g4.xz = n_xz;
        n_g4.on_axis = (n_xx == 0) && (n_xy == 0) && (n_xz == 0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= '0;
        else r_v <= {r_v[4:0], i_start};
        r_g0 <= n_g0;
        r_z0 <= t_ang'(i_angle) <<< 2;
        r_g1 <= n_g1;
        r_m0 <= 52'(r_g0.vx * r_g0.ux);
        r_m1 <= 52'(r_g0.vy * r_g0.uy);
        r_m2 <= 52'(r_g0.vz * r_g0.uz);
        r_z1 <= n_zb;
        r_g2 <= n_g2;
        r_z2 <= r_z1;
        r_g3 <= n_g3;
        r_z3 <= r_z2;
        r_g4 <= n_g4;
        r_z4 <= r_z3;
        r_c0 <= 56'(r_g4.uy * r_g4.xz); r_c1 <= 56'(r_g4.uz * r_g4.xy);
        r_c2 <= 56'(r_g4.uz * r_g4.xx); r_c3 <= 56'(r_g4.ux * r_g4.xz);
        r_c4 <= 56'(r_g4.ux * r_g4.xy); r_c5 <= 56'(r_g4.uy * r_g4.xx);
        r_g5 <= r_g4;
        r_z5 <= r_z4;
    end

    t_geo g_in;
    always_comb begin
        g_in = r_g5;
        g_in.yx = 39'((r_c0 - r_c1 + 56'sd32768) >>> 16);
        g_in.yy = 39'((r_c2 - r_c3 + 56'sd32768) >>> 16);
        g_in.yz = 39'((r_c4 - r_c5 + 56'sd32768) >>> 16);
    end

    logic  c_v [0:N_CORDIC];
    t_trig c_x [0:N_CORDIC];
    t_trig c_y [0:N_CORDIC];
    t_ang  c_z [0:N_CORDIC];
    t_geo  c_g [0:N_CORDIC];
    assign c_v[0] = r_v[5];
    assign c_x[0] = CORDIC_K;
    assign c_y[0] = '0;
    assign c_z[0] = r_z5;
    assign c_g[0] = g_in;

    for (genvar i = 0; i < N_CORDIC; i++) begin : g_cell
        rpa_cell #(.STEP(i)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n),
            .i_vld(c_v[i]), .i_x(c_x[i]), .i_y(c_y[i]), .i_z(c_z[i]), .i_geo(c_g[i]),
            .o_vld(c_v[i+1]), .o_x(c_x[i+1]), .o_y(c_y[i+1]), .o_z(c_z[i+1]),
            .o_geo(c_g[i+1])
        );
    end

    t_geo f_g;
    t_trig f_cx, f_cy;
    assign f_g = c_g[N_CORDIC];
    assign f_cx = f_g.flip ? -c_x[N_CORDIC] : c_x[N_CORDIC];
    assign f_cy = f_g.flip ? -c_y[N_CORDIC] : c_y[N_CORDIC];

    logic [3:0] r_ov;
    t_geo r_h0, r_h1, r_h2;
    logic signed [24:0] r_cos, r_sin;
    logic signed [61:0] r_p0, r_p1, r_p2, r_p3, r_p4, r_p5;
    logic signed [39:0] r_sx, r_sy, r_sz;
    logic signed [31:0] r_ox, r_oy, r_oz;
    logic r_oa;

    function automatic logic signed [31:0] sat(input logic signed [39:0] v);
        if (v > 40'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -40'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [39:0] comb3(input logic signed [31:0] a,
                                                 input logic signed [36:0] w,
                                                 input logic signed [61:0] p,
                                                 input logic signed [61:0] q);
        logic signed [62:0] t;
        t = 63'(p) + 63'(q) + 63'sd524288;
        return 40'(a) + 40'(w) + 40'(t >>> 20);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= '0;
            o_done <= 1'b0;
        end else begin
            r_ov <= {r_ov[2:0], c_v[N_CORDIC]};
            o_done <= r_ov[3];
        end
        r_h0 <= f_g;
        r_cos <= 25'((f_cx + 34'sd512) >>> 10);
        r_sin <= 25'((f_cy + 34'sd512) >>> 10);
        r_h1 <= r_h0;
        r_p0 <= 62'(r_cos * r_h0.xx); r_p1 <= 62'(r_sin * r_h0.yx);
        r_p2 <= 62'(r_cos * r_h0.xy); r_p3 <= 62'(r_sin * r_h0.yy);
        r_p4 <= 62'(r_cos * r_h0.xz); r_p5 <= 62'(r_sin * r_h0.yz);
        r_h2 <= r_h1;
        r_sx <= comb3(r_h1.ax, r_h1.wx, r_p0, r_p1);
        r_sy <= comb3(r_h1.ay, r_h1.wy, r_p2, r_p3);
        r_sz <= comb3(r_h1.az, r_h1.wz, r_p4, r_p5);
        r_ox <= r_h2.on_axis ? r_h2.px : sat(r_sx);
        r_oy <= r_h2.on_axis ? r_h2.py : sat(r_sy);
        r_oz <= r_h2.on_axis ? r_h2.pz : sat(r_sz);
        r_oa <= r_h2.on_axis;
        o_rotated_x <= r_ox;
        o_rotated_y <= r_oy;
        o_rotated_z <= r_oz;
        o_on_axis <= r_oa;
    end
endmodule
`default_nettype wire

FILE: tb/rotate_point_about_axis_tb.sv
`timescale 1ns / 1ps
module rotate_point_about_axis_tb;
    localparam int LATENCY = 42;
    localparam longint ANG_PI = 64'sd3373259426;
    localparam longint ANG_TWO_PI = 64'sd6746518852;
    localparam longint ANG_HALF_PI = 64'sd1686629713;
    localparam longint GAIN_START = 64'sd652032874;

    typedef struct {
        logic signed [31:0] rx, ry, rz;
        logic               on_axis;
    } t_rotated;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_start = 1'b0;
    logic               o_busy;
    logic signed [31:0] i_point_x = '0, i_point_y = '0, i_point_z = '0;
    logic signed [31:0] i_anchor_x = '0, i_anchor_y = '0, i_anchor_z = '0;
    logic signed [17:0] i_axis_x = '0, i_axis_y = '0, i_axis_z = '0;
    logic signed [31:0] i_angle = '0;
    logic               o_done;
    logic signed [31:0] o_rotated_x, o_rotated_y, o_rotated_z;
    logic               o_on_axis;

    t_rotated rotated_q[$];
    int       errors = 0;
    int       send_idle_pct = 0;

    rotate_point_about_axis dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_point_x(i_point_x), .i_point_y(i_point_y), .i_point_z(i_point_z),
        .i_anchor_x(i_anchor_x), .i_anchor_y(i_anchor_y), .i_anchor_z(i_anchor_z),
        .i_axis_x(i_axis_x), .i_axis_y(i_axis_y), .i_axis_z(i_axis_z),
        .i_angle(i_angle), .o_done(o_done),
        .o_rotated_x(o_rotated_x), .o_rotated_y(o_rotated_y),
        .o_rotated_z(o_rotated_z), .o_on_axis(o_on_axis)
    );

    always #5 i_clk = ~i_clk;

    function automatic longint floor_shift(longint v, int sh);
        return v >>> sh;
    endfunction

    function automatic longint round_shift(longint v, int sh);
        return (v + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic longint atan_entry(int i);
        longint tab [0:30];
        tab = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
                64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
                64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
                64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
                64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
                64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
                64'h00000001};
        return tab[i];
    endfunction

    task automatic cos_sin_q20(input logic signed [31:0] ang, output longint c,
                               output longint s);
        longint z, cx, cy, dx, dy;
        bit     flip;
        z = longint'(ang) * 4;
        cx = GAIN_START;
        cy = 0;
        flip = 1'b0;
        if (z > ANG_PI) z -= ANG_TWO_PI;
        if (z < -ANG_PI) z += ANG_TWO_PI;
        if (z > ANG_HALF_PI) begin
            z -= ANG_PI;
            flip = 1'b1;
        end else if (z < -ANG_HALF_PI) begin
            z += ANG_PI;
            flip = 1'b1;
        end
        for (int i = 0; i < 31; i++) begin
            dx = floor_shift(cy, i);
            dy = floor_shift(cx, i);
            if (z >= 0) begin
                cx -= dx; cy += dy; z -= atan_entry(i);
            end else begin
                cx += dx; cy -= dy; z += atan_entry(i);
            end
        end
        if (flip) begin
            cx = -cx;
            cy = -cy;
        end
        c = round_shift(cx, 10);
        s = round_shift(cy, 10);
    endtask

    task automatic predict_rotation(input logic signed [31:0] p[3],
                                    input logic signed [31:0] a[3],
                                    input logic signed [17:0] u[3],
                                    input logic signed [31:0] ang);
        longint   v[3], w[3], x[3], y[3], uu[3];
        longint   s, c, sn;
        t_rotated r;
        for (int k = 0; k < 3; k++) begin
            uu[k] = u[k];
            v[k] = longint'(p[k]) - longint'(a[k]);
        end
        s = round_shift(v[0] * uu[0] + v[1] * uu[1] + v[2] * uu[2], 16);
        for (int k = 0; k < 3; k++) begin
            w[k] = round_shift(s * uu[k], 16);
            x[k] = v[k] - w[k];
        end
        if (x[0] == 0 && x[1] == 0 && x[2] == 0) begin
            r.rx = p[0]; r.ry = p[1]; r.rz = p[2];
            r.on_axis = 1'b1;
        end else begin
            y[0] = round_shift(uu[1] * x[2] - uu[2] * x[1], 16);
            y[1] = round_shift(uu[2] * x[0] - uu[0] * x[2], 16);
            y[2] = round_shift(uu[0] * x[1] - uu[1] * x[0], 16);
            cos_sin_q20(ang, c, sn);
            r.rx = clamp32(a[0] + w[0] + round_shift(c * x[0] + sn * y[0], 20));
            r.ry = clamp32(a[1] + w[1] + round_shift(c * x[1] + sn * y[1], 20));
            r.rz = clamp32(a[2] + w[2] + round_shift(c * x[2] + sn * y[2], 20));
            r.on_axis = 1'b0;
        end
        rotated_q.push_back(r);
    endtask

    task automatic send_word(input logic signed [31:0] p[3], input logic signed [31:0] a[3],
                             input logic signed [17:0] u[3], input logic signed [31:0] ang);
        while ($urandom_range(99) < send_idle_pct) begin
            i_start <= 1'b0;
            @(negedge i_clk);
        end
        i_start <= 1'b1;
        i_point_x <= p[0]; i_point_y <= p[1]; i_point_z <= p[2];
        i_anchor_x <= a[0]; i_anchor_y <= a[1]; i_anchor_z <= a[2];
        i_axis_x <= u[0]; i_axis_y <= u[1]; i_axis_z <= u[2];
        i_angle <= ang;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        predict_rotation(p, a, u, ang);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_start <= 1'b0;
        while (rotated_q.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 5) @(negedge i_clk);
    endtask

    function automatic logic signed [31:0] rand32();
        case ($urandom_range(5))
            0: return 32'sh7fffffff - $urandom_range(3);
            1: return 32'sh80000000 + $urandom_range(3);
            2: return $signed($urandom_range(2000000)) - 1000000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [17:0] rand_axis();
        if ($urandom_range(3) == 0) return 18'($urandom);
        return 18'($signed($urandom_range(131072)) - 65536);
    endfunction

    task automatic test_directed();
        logic signed [31:0] p[3], a[3];
        logic signed [17:0] u[3];
        logic signed [31:0] angs[8];
        angs = '{32'sh0, 32'sh7fffffff, 32'sh80000000, 32'sd421657428,
                 32'sd843314857, -32'sd843314857, 32'sd1686629713, -32'sd421657428};
        foreach (angs[i]) begin
            p = '{32'sh00010000, 32'sh00020000, -32'sh00030000};
            a = '{0, 0, 0};
            u = '{18'sh0, 18'sh0, 18'sh10000};
            send_word(p, a, u, angs[i]);
        end
        // Points on the axis, including the all-zero point.
        p = '{32'sh5, 32'sh7, 32'sh00100000}; a = '{32'sh5, 32'sh7, 0};
        send_word(p, a, u, 32'sd1000);
        p = '{0, 0, 0}; a = '{0, 0, 0};
        send_word(p, a, u, 32'sd1000);
        // Saturation at both ends and extreme axis values.
        p = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff};
        a = '{32'sh80000000, 32'sh7fffffff, 32'sh80000000};
        u = '{18'sh1ffff, 18'sh20000, 18'sh1ffff};
        send_word(p, a, u, 32'sd843314857);
        u = '{18'sh20000, 18'sh20000, 18'sh20000};
        send_word(p, a, u, 32'sh80000000);
        u = '{18'sh0, 18'sh0, 18'sh0};
        send_word(p, a, u, 32'sh7fffffff);
        // An axis that is not of unit length.
        p = '{32'sh00030000, 32'sh00010000, 32'sh0}; a = '{0, 0, 0};
        u = '{18'sh8000, 18'sh8000, 18'sh0};
        send_word(p, a, u, 32'sd421657428);
        wait_drained();
    endtask

    task automatic test_random(input int count);
        logic signed [31:0] p[3], a[3], ang;
        logic signed [17:0] u[3];
        for (int n = 0; n < count; n++) begin
            for (int k = 0; k < 3; k++) begin
                a[k] = rand32();
                u[k] = rand_axis();
            end
            case ($urandom_range(9))
                // Point placed on a principal axis through the anchor.
                0: begin
                    u = '{18'sh0, 18'sh0, 18'sh0};
                    u[$urandom_range(2)] = ($urandom_range(1) ? 18'sh10000 : -18'sh10000);
                    for (int k = 0; k < 3; k++) p[k] = (u[k] != 0) ? rand32() : a[k];
                end
                1, 2, 3: for (int k = 0; k < 3; k++)
                    p[k] = a[k] + ($signed($urandom_range(2000000)) - 1000000);
                default: for (int k = 0; k < 3; k++) p[k] = rand32();
            endcase
            ang = $urandom_range(1) ? $urandom : $signed($urandom_range(1686629713)) - 843314856;
            send_word(p, a, u, ang);
        end
    endtask

    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        send_idle_pct = 0;
        test_directed();
        send_idle_pct = 18;
        test_random(580);
        wait_drained();
        send_idle_pct = 52;
        test_random(580);
        send_idle_pct = 0;
        test_random(580);
        wait_drained();
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        t_rotated e;
        if (i_rst_n && o_done) begin
            if (rotated_q.size() == 0) begin
                $display("%0t: unexpected word x=%h y=%h z=%h flag=%b", $time,
                         o_rotated_x, o_rotated_y, o_rotated_z, o_on_axis);
                errors++;
            end else begin
                e = rotated_q.pop_front();
                if (o_rotated_x !== e.rx || o_rotated_y !== e.ry ||
                    o_rotated_z !== e.rz || o_on_axis !== e.on_axis) begin
                    $display("%0t: expected x=%h y=%h z=%h flag=%b actual x=%h y=%h z=%h flag=%b",
                             $time, e.rx, e.ry, e.rz, e.on_axis,
                             o_rotated_x, o_rotated_y, o_rotated_z, o_on_axis);
                    errors++;
                end
            end
        end
    end

    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule

FILE: filelist.f
rtl/rpa_pkg.sv
rtl/rpa_cell.sv
rtl/rotate_point_about_axis.sv
tb/rotate_point_about_axis_tb.sv
